// ===== sv/qta_pkg.sv =====
// Shared constants, types and tile helpers of the quadtree tile allocator.
`default_nettype none
package qta_pkg;

  localparam int ATLAS_EDGE   = 4096;
  localparam int LARGEST_TILE = 1024;
  localparam int CLASS_COUNT  = 4;
  localparam int MAX_RUN      = 6;

  localparam int GRID_SIDE   = (ATLAS_EDGE + LARGEST_TILE - 1) / LARGEST_TILE;
  localparam int TOP_DEPTH   = GRID_SIDE * GRID_SIDE;
  localparam int SPLIT_DEPTH = 3;

  // Field widths of the item formats
  localparam int CMD_W   = 1;
  localparam int CLSIN_W = 4;
  localparam int CNT_W   = 3;
  localparam int COORD_W = 12;
  localparam int EDGE_W  = 11;
  localparam int TILES_W = 11;
  localparam int AREA_W  = 25;

  localparam int CLS_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int TOP_FW  = $clog2(TOP_DEPTH + 1);
  localparam int TOP_IW  = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
  localparam int SPL_FW  = 2;
  localparam int RUN_IW  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

  localparam logic [CMD_W-1:0] CMD_RESET = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic              seed;
    logic              snap;
    logic              restore;
    logic              pop;
    logic              split;
    logic              store;
    logic              emit;
    logic              emit_ok;
    logic              emit_last;
    logic              emit_tile;
    logic [CLS_W-1:0]  cls;
    logic [RUN_IW-1:0] idx;
  } qta_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic found;
    logic at_class;
    logic out_free;
  } qta_stat_t;

  // Left edge of a seeded largest tile at stack position idx
  function automatic logic [COORD_W-1:0] top_x(input logic [TOP_IW-1:0] idx);
    return COORD_W'((32'(idx) % GRID_SIDE) * LARGEST_TILE);
  endfunction

  // Top edge of a seeded largest tile at stack position idx
  function automatic logic [COORD_W-1:0] top_y(input logic [TOP_IW-1:0] idx);
    return COORD_W'((32'(idx) / GRID_SIDE) * LARGEST_TILE);
  endfunction

  function automatic logic [EDGE_W-1:0] class_edge(input logic [CLS_W-1:0] c);
    return EDGE_W'(LARGEST_TILE) >> c;
  endfunction

  function automatic logic [AREA_W-1:0] class_area(input logic [CLS_W-1:0] c);
    return AREA_W'(LARGEST_TILE * LARGEST_TILE) >> (2 * c);
  endfunction

endpackage
`default_nettype wire

// ===== sv/quadtree_tile_allocator.sv =====
// Top level of the quadtree tile allocator.
//
//  channel | dir | handshake          | contents
//  s       | in  | s_tvalid/s_tready  | tuser: command; tdata: size_class, tile_count
//  m       | out | m_tvalid/m_tready  | tuser: success; tlast: last_of_run; tdata: tiles
//
// A request is accepted and decoded, then for each tile a free tile is popped, split
// once per level down to the requested class and stored; the results then leave
// one at a time through the single output register.
// rst clears fills and totals to the seeded atlas at once; no clearing pass.
// A stalled output holds the sequencer; no new item is taken until the last
// result of a request is loaded.
`default_nettype none
module quadtree_tile_allocator
  import qta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // size_class[3:0], tile_count[6:4], zero[7]
  input  wire logic        s_tuser,   // command
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // tile_x, tile_y, tile_edge, tiles_in_use,
                                      // area_in_use, zero[71]
  output logic             m_tuser,   // success
  output logic             m_tlast
);

  qta_cmd_t  cmd;
  qta_stat_t stat;

  qta_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .command    (s_tuser),
    .size_class (s_tdata[3:0]),
    .tile_count (s_tdata[6:4]),
    .stat       (stat),
    .cmd        (cmd)
  );

  qta_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== sv/qta_dp.sv =====
// Datapath of the quadtree tile allocator: free stacks, snapshot, tiles, totals, output.
`default_nettype none
module qta_dp
  import qta_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire qta_cmd_t            cmd,
  output qta_stat_t                stat,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [71:0]              m_tdata,
  output logic                     m_tuser,
  output logic                     m_tlast
);

  logic [TOP_FW-1:0]  top_fill;
  logic [TOP_FW-1:0]  top_fill_rb;
  logic [SPL_FW-1:0]  spl_fill    [CLASS_COUNT];
  logic [SPL_FW-1:0]  spl_fill_rb [CLASS_COUNT];
  logic [COORD_W-1:0] spl_x    [CLASS_COUNT][SPLIT_DEPTH];
  logic [COORD_W-1:0] spl_y    [CLASS_COUNT][SPLIT_DEPTH];
  logic [COORD_W-1:0] spl_x_rb [CLASS_COUNT][SPLIT_DEPTH];
  logic [COORD_W-1:0] spl_y_rb [CLASS_COUNT][SPLIT_DEPTH];
  logic [COORD_W-1:0] got_x [MAX_RUN];
  logic [COORD_W-1:0] got_y [MAX_RUN];
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [CLS_W-1:0]   lvl;
  logic [TILES_W-1:0] tiles;
  logic [AREA_W-1:0]  area;
  logic               found;
  logic [CLS_W-1:0]   k;
  logic [TOP_IW-1:0]  top_idx;
  logic [SPL_FW-1:0]  spl_idx;
  logic [CLS_W-1:0]   nxt;
  logic [COORD_W-1:0] half;
  logic [TILES_W-1:0] tiles_next;
  logic [AREA_W-1:0]  area_next;

  // Find the nearest non-empty class at or above the requested one
  always_comb begin
    found = 1'b0;
    k     = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (CLS_W'(c) <= cmd.cls) begin
        if ((c == 0) ? (top_fill != '0) : (spl_fill[c] != '0)) begin
          found = 1'b1;
          k     = CLS_W'(c);
        end
      end
    end
  end

  assign top_idx    = TOP_IW'(top_fill - TOP_FW'(1));
  assign spl_idx    = spl_fill[k] - SPL_FW'(1);
  assign nxt        = lvl + CLS_W'(1);
  assign half       = COORD_W'(class_edge(nxt));
  assign tiles_next = tiles + TILES_W'(1);
  assign area_next  = area + class_area(cmd.cls);

  assign stat.found    = found;
  assign stat.at_class = (lvl == cmd.cls);
  assign stat.out_free = !m_tvalid || m_tready;

  // Fill counts and totals
  always_ff @(posedge clk) begin
    if (rst || cmd.seed) begin
      top_fill <= TOP_FW'(TOP_DEPTH);
      for (int c = 0; c < CLASS_COUNT; c++) spl_fill[c] <= '0;
      tiles <= '0;
      area  <= '0;
    end else begin
      if (cmd.restore) begin
        top_fill <= top_fill_rb;
        for (int c = 0; c < CLASS_COUNT; c++) spl_fill[c] <= spl_fill_rb[c];
      end
      if (cmd.pop) begin
        if (k == '0) top_fill <= top_fill - TOP_FW'(1);
        else spl_fill[k] <= spl_idx;
      end
      if (cmd.split) spl_fill[nxt] <= SPL_FW'(SPLIT_DEPTH);
      if (cmd.emit && cmd.emit_tile) begin
        tiles <= tiles_next;
        area  <= area_next;
      end
    end
  end

  // Stack contents, snapshot and working tile
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      top_fill_rb <= top_fill;
      for (int c = 0; c < CLASS_COUNT; c++) begin
        spl_fill_rb[c] <= spl_fill[c];
        for (int e = 0; e < SPLIT_DEPTH; e++) begin
          spl_x_rb[c][e] <= spl_x[c][e];
          spl_y_rb[c][e] <= spl_y[c][e];
        end
      end
    end
    if (cmd.restore) begin
      for (int c = 0; c < CLASS_COUNT; c++) begin
        for (int e = 0; e < SPLIT_DEPTH; e++) begin
          spl_x[c][e] <= spl_x_rb[c][e];
          spl_y[c][e] <= spl_y_rb[c][e];
        end
      end
    end
    if (cmd.pop) begin
      lvl <= k;
      if (k == '0) begin
        cur_x <= top_x(top_idx);
        cur_y <= top_y(top_idx);
      end else begin
        cur_x <= spl_x[k][spl_idx];
        cur_y <= spl_y[k][spl_idx];
      end
    end
    // Keep the top-left quadrant, push the other three
    if (cmd.split) begin
      spl_x[nxt][0] <= cur_x + half;
      spl_y[nxt][0] <= cur_y;
      spl_x[nxt][1] <= cur_x;
      spl_y[nxt][1] <= cur_y + half;
      spl_x[nxt][2] <= cur_x + half;
      spl_y[nxt][2] <= cur_y + half;
      lvl <= nxt;
    end
    if (cmd.store) begin
      got_x[cmd.idx] <= cur_x;
      got_y[cmd.idx] <= cur_y;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= cmd.emit_ok;
      m_tlast <= cmd.emit_last;
      if (cmd.emit_tile) begin
        m_tdata <= {1'b0, area_next, tiles_next, class_edge(cmd.cls),
                    got_y[cmd.idx], got_x[cmd.idx]};
      end else begin
        m_tdata <= {1'b0, area, tiles, EDGE_W'(0), COORD_W'(0), COORD_W'(0)};
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/qta_ctrl.sv =====
// Controller of the quadtree tile allocator: request sequencing state machine.
`default_nettype none
module qta_ctrl
  import qta_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [CLSIN_W-1:0] size_class,
  input  wire logic [CNT_W-1:0]   tile_count,
  input  wire qta_stat_t          stat,
  output qta_cmd_t                cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAKE  = 3'd1;
  localparam logic [2:0] S_SPLIT = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FAIL  = 3'd4;
  localparam logic [2:0] S_ACK   = 3'd5;

  logic [2:0]        state, state_next;
  logic [CLS_W-1:0]  cls;
  logic [CNT_W-1:0]  cnt;
  logic [RUN_IW-1:0] cnt_i;
  logic [CLS_W-1:0]  cls_clamped;
  logic              accept;
  logic              last_take;
  logic              last_emit;

  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign cls_clamped = (size_class > CLSIN_W'(CLASS_COUNT - 1))
                       ? CLS_W'(CLASS_COUNT - 1) : CLS_W'(size_class);
  assign last_take   = (CNT_W'(cnt_i) + CNT_W'(1) == cnt);
  assign last_emit   = last_take;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.cls    = cls;
    cmd.idx    = cnt_i;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (command == CMD_RESET) begin
            cmd.seed   = 1'b1;
            state_next = S_ACK;
          end else if (tile_count == '0 || tile_count > CNT_W'(MAX_RUN)) begin
            state_next = S_FAIL;
          end else begin
            cmd.snap   = 1'b1;
            state_next = S_TAKE;
          end
        end
      end
      S_TAKE: begin
        if (stat.found) begin
          cmd.pop    = 1'b1;
          state_next = S_SPLIT;
        end else begin
          cmd.restore = 1'b1;
          state_next  = S_FAIL;
        end
      end
      S_SPLIT: begin
        if (stat.at_class) begin
          cmd.store  = 1'b1;
          state_next = last_take ? S_EMIT : S_TAKE;
        end else begin
          cmd.split = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_ok   = 1'b1;
          cmd.emit_tile = 1'b1;
          cmd.emit_last = last_emit;
          if (last_emit) state_next = S_IDLE;
        end
      end
      S_FAIL, S_ACK: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_ok   = (state == S_ACK);
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold request, advance counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt_i <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cls   <= cls_clamped;
        cnt   <= tile_count;
        cnt_i <= '0;
      end else if (cmd.store) begin
        cnt_i <= last_take ? '0 : cnt_i + RUN_IW'(1);
      end else if (cmd.emit && cmd.emit_tile) begin
        cnt_i <= cnt_i + RUN_IW'(1);
      end
    end
  end

endmodule
`default_nettype wire
